@@ sv/cc20_pkg.sv @@
// shared types, constants and state builder for the chacha20 stream cipher
// no dependencies; imported by cc20_round and chacha20_stream_cipher

package cc20_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int STATE_WORDS       = 16;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    // word i of the cipher state sits at index i
    typedef logic [STATE_WORDS-1:0][31:0] state_t;

    typedef enum logic [2:0] {
        CFG_KEY_PAIR_0      = 3'd0,
        CFG_KEY_PAIR_1      = 3'd1,
        CFG_KEY_PAIR_2      = 3'd2,
        CFG_KEY_PAIR_3      = 3'd3,
        CFG_NONCE_LOW       = 3'd4,
        CFG_NONCE_HIGH      = 3'd5,
        CFG_INITIAL_COUNTER = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_XOR
    } seq_state_t;

    // start state: constants, key, block counter, nonce
    function automatic state_t build_state(
        input logic [63:0] kp0,
        input logic [63:0] kp1,
        input logic [63:0] kp2,
        input logic [63:0] kp3,
        input logic [63:0] nlow,
        input logic [31:0] nhigh,
        input logic [31:0] ctr
    );
        state_t s;
        s[0]  = SIGMA0;
        s[1]  = SIGMA1;
        s[2]  = SIGMA2;
        s[3]  = SIGMA3;
        s[4]  = kp0[31:0];
        s[5]  = kp0[63:32];
        s[6]  = kp1[31:0];
        s[7]  = kp1[63:32];
        s[8]  = kp2[31:0];
        s[9]  = kp2[63:32];
        s[10] = kp3[31:0];
        s[11] = kp3[63:32];
        s[12] = ctr;
        s[13] = nlow[31:0];
        s[14] = nlow[63:32];
        s[15] = nhigh;
        return s;
    endfunction

endpackage

@@ sv/cc20_if.sv @@
// valid/ready stream interfaces for message words in and result words out
// no dependencies

interface cc20_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last;

    modport source (output valid, output data_word, output valid_bytes, output last,
                    input ready);
    modport sink   (input valid, input data_word, input valid_bytes, input last,
                    output ready);
endinterface

interface cc20_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_word;
    logic [2:0]  result_bytes;
    logic        result_last;

    modport source (output valid, output result_word, output result_bytes,
                    output result_last, input ready);
    modport sink   (input valid, input result_word, input result_bytes,
                    input result_last, output ready);
endinterface

@@ sv/cc20_qround.sv @@
// one chacha quarter round on four 32-bit words, combinational
// no dependencies

module cc20_qround (
    input  logic [31:0] a_in,
    input  logic [31:0] b_in,
    input  logic [31:0] c_in,
    input  logic [31:0] d_in,
    output logic [31:0] a_out,
    output logic [31:0] b_out,
    output logic [31:0] c_out,
    output logic [31:0] d_out
);

    logic [31:0] a1, b1, c1, d1;
    logic [31:0] a2, b2, c2, d2;
    logic [31:0] x_d1, x_b1, x_d2, x_b2;

    always_comb
    begin
        a1   = a_in + b_in;
        x_d1 = d_in ^ a1;
        d1   = {x_d1[15:0], x_d1[31:16]};
        c1   = c_in + d1;
        x_b1 = b_in ^ c1;
        b1   = {x_b1[19:0], x_b1[31:20]};
        a2   = a1 + b1;
        x_d2 = d1 ^ a2;
        d2   = {x_d2[23:0], x_d2[31:24]};
        c2   = c1 + d2;
        x_b2 = b1 ^ c2;
        b2   = {x_b2[24:0], x_b2[31:25]};
    end

    assign a_out = a2;
    assign b_out = b2;
    assign c_out = c2;
    assign d_out = d2;

endmodule

@@ sv/cc20_round.sv @@
// shared round unit: four quarter-round lanes, column or diagonal wiring
// depends on cc20_pkg and cc20_qround

module cc20_round
    import cc20_pkg::*;
(
    input  state_t s_in,
    input  logic   diag,
    output state_t s_out
);

    logic [3:0][31:0] qa, qb, qc, qd;

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        localparam int BC = 4 + k;
        localparam int CC = 8 + k;
        localparam int DC = 12 + k;
        localparam int BD = 4 + ((k + 1) % 4);
        localparam int CD = 8 + ((k + 2) % 4);
        localparam int DD = 12 + ((k + 3) % 4);

        cc20_qround u_qround (
            .a_in  (s_in[k]),
            .b_in  (diag ? s_in[BD] : s_in[BC]),
            .c_in  (diag ? s_in[CD] : s_in[CC]),
            .d_in  (diag ? s_in[DD] : s_in[DC]),
            .a_out (qa[k]),
            .b_out (qb[k]),
            .c_out (qc[k]),
            .d_out (qd[k])
        );
    end

    // route lane results back to their state words
    for (genvar c = 0; c < 4; c++)
    begin : g_back
        assign s_out[c]      = qa[c];
        assign s_out[4 + c]  = diag ? qb[(c + 3) % 4] : qb[c];
        assign s_out[8 + c]  = diag ? qc[(c + 2) % 4] : qc[c];
        assign s_out[12 + c] = diag ? qd[(c + 1) % 4] : qd[c];
    end

endmodule

@@ sv/chacha20_stream_cipher.sv @@
// chacha20 stream cipher top level: config registers, sequencer, keystream xor
// depends on cc20_pkg, cc20_if and cc20_round
//
//   channel  role    carries
//   din      sink    data_word, valid_bytes, last
//   dout     source  result_word, result_bytes, result_last
//   config   write   write_enable, write_index, write_data (64 bits)
//
// a word that opens a 64-byte block is accepted, then goes through the rounds,
// one round per cycle in the shared round unit, the final add, then the xor into
// the output register; any other word goes from accept straight to the xor
// one word is in flight at a time; din is ready only in idle with the output
// register free or being taken, so a stalled dout holds off the next word
// reset clears the config registers, counter, position and message flag

module chacha20_stream_cipher
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    cc20_in_if.sink           din,
    cc20_out_if.source        dout,
    input  logic              write_enable,
    input  logic [2:0]        write_index,
    input  logic [63:0]       write_data
);

    localparam int RND_W = $clog2(2 * DOUBLE_ROUNDS);
    localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(2 * DOUBLE_ROUNDS - 1);

    logic [63:0] key_pair0_reg, key_pair1_reg, key_pair2_reg, key_pair3_reg;
    logic [63:0] nonce_low_reg;
    logic [31:0] nonce_high_reg;
    logic [31:0] initial_counter_reg;

    seq_state_t       state_reg, state_next;
    logic [RND_W-1:0] round_reg, round_next;
    logic [3:0]       pos_reg, pos_next;
    logic [31:0]      counter_reg, counter_next;
    logic             open_reg, open_next;
    state_t           work_reg, work_next;
    logic [31:0]      data_reg, data_next;
    logic [2:0]       nbytes_reg, nbytes_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_word_reg, out_word_next;
    logic [2:0]       out_bytes_reg, out_bytes_next;
    logic             out_last_reg, out_last_next;

    logic        in_ready;
    logic        accept;
    logic        need_block;
    logic [31:0] counter_sel;
    state_t      init_words;
    state_t      round_out;
    logic [31:0] byte_mask;

    cc20_round u_round (
        .s_in  (work_reg),
        .diag  (round_reg[0]),
        .s_out (round_out)
    );

    assign accept      = din.valid && in_ready;
    assign need_block  = !open_reg || (pos_reg == 4'd0);
    assign counter_sel = open_reg ? counter_reg : initial_counter_reg;
    assign init_words  = build_state(key_pair0_reg, key_pair1_reg, key_pair2_reg,
                                     key_pair3_reg, nonce_low_reg, nonce_high_reg,
                                     counter_reg);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            byte_mask[8*i +: 8] = (3'(i) < nbytes_reg) ? 8'hff : 8'h00;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_block ? ST_ROUND : ST_XOR;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: state_next = ST_XOR;
            ST_XOR:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE) && (!out_valid_reg || dout.ready);
        round_next     = round_reg;
        pos_next       = pos_reg;
        counter_next   = counter_reg;
        open_next      = open_reg;
        work_next      = work_reg;
        data_next      = data_reg;
        nbytes_next    = nbytes_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_bytes_next = out_bytes_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    data_next   = din.data_word;
                    nbytes_next = (din.valid_bytes > 3'd4) ? 3'd4 : din.valid_bytes;
                    last_next   = din.last;
                    if (!open_reg)
                    begin
                        pos_next  = 4'd0;
                        open_next = 1'b1;
                    end
                    if (need_block)
                    begin
                        counter_next = counter_sel;
                        round_next   = '0;
                        work_next    = build_state(key_pair0_reg, key_pair1_reg,
                                                   key_pair2_reg, key_pair3_reg,
                                                   nonce_low_reg, nonce_high_reg,
                                                   counter_sel);
                    end
                end
            end
            ST_ROUND:
            begin
                work_next  = round_out;
                round_next = round_reg + 1'b1;
            end
            ST_FINAL:
            begin
                for (int i = 0; i < STATE_WORDS; i++)
                begin
                    work_next[i] = work_reg[i] + init_words[i];
                end
                counter_next = counter_reg + 32'd1;
            end
            ST_XOR:
            begin
                out_valid_next = 1'b1;
                out_word_next  = (data_reg ^ work_reg[pos_reg]) & byte_mask;
                out_bytes_next = nbytes_reg;
                out_last_next  = last_reg;
                pos_next       = last_reg ? 4'd0 : pos_reg + 4'd1;
                open_next      = !last_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_pair0_reg       <= '0;
            key_pair1_reg       <= '0;
            key_pair2_reg       <= '0;
            key_pair3_reg       <= '0;
            nonce_low_reg       <= '0;
            nonce_high_reg      <= '0;
            initial_counter_reg <= '0;
        end
        else if (write_enable)
        begin
            unique case (cfg_index_t'(write_index))
                CFG_KEY_PAIR_0:      key_pair0_reg       <= write_data;
                CFG_KEY_PAIR_1:      key_pair1_reg       <= write_data;
                CFG_KEY_PAIR_2:      key_pair2_reg       <= write_data;
                CFG_KEY_PAIR_3:      key_pair3_reg       <= write_data;
                CFG_NONCE_LOW:       nonce_low_reg       <= write_data;
                CFG_NONCE_HIGH:      nonce_high_reg      <= write_data[31:0];
                CFG_INITIAL_COUNTER: initial_counter_reg <= write_data[31:0];
                default:             ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            pos_reg       <= '0;
            counter_reg   <= '0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            pos_reg       <= pos_next;
            counter_reg   <= counter_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        data_reg      <= data_next;
        nbytes_reg    <= nbytes_next;
        last_reg      <= last_next;
        out_word_reg  <= out_word_next;
        out_bytes_reg <= out_bytes_next;
        out_last_reg  <= out_last_next;
    end

    assign din.ready         = in_ready;
    assign dout.valid        = out_valid_reg;
    assign dout.result_word  = out_word_reg;
    assign dout.result_bytes = out_bytes_reg;
    assign dout.result_last  = out_last_reg;

endmodule
